/* sv/pcapdf_pkg.sv */
// Package: shared types, constants and helper functions for the pcap record deframer.
package pcapdf_pkg;

  typedef enum logic [2:0] {
    PH_GLOBAL = 3'd0,
    PH_RECHDR = 3'd1,
    PH_KEEP   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_TOO_SHORT    = 3'd0,
    ERR_BAD_MAGIC    = 3'd1,
    ERR_BAD_MAJOR    = 3'd2,
    ERR_BAD_RECORD   = 3'd3,
    ERR_SHORT_PACKET = 3'd4
  } err_t;

  localparam logic [1:0] CFG_PROB     = 2'd0;
  localparam logic [1:0] CFG_SEED     = 2'd1;
  localparam logic [1:0] CFG_RAW_LINK = 2'd2;

  localparam logic [31:0] PCAP_MAGIC     = 32'hA1B2_C3D4;
  localparam logic [15:0] PCAP_MAJOR     = 16'd2;
  localparam logic [28:0] FULL_PROB      = 29'h1000_0000;
  localparam logic [15:0] MIN_IP_LEN     = 16'd20;
  localparam logic [31:0] LFSR_TAPS      = 32'h8020_0003;
  localparam logic [31:0] SEED_RESET     = 32'd1;
  localparam logic [31:0] RAW_LINK_RESET = 32'd12;

  // byte positions inside the global header and a record header
  localparam logic [4:0] MAGIC_END   = 5'd4;
  localparam logic [4:0] VER_END     = 5'd8;
  localparam logic [4:0] LINK_START  = 5'd20;
  localparam logic [4:0] GLOBAL_LAST = 5'd23;
  localparam logic [4:0] RECHDR_LAST = 5'd15;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] sec;
    logic [31:0] usec;
    logic [15:0] cap;
    logic [31:0] wire_len;
    logic [5:0]  ip;
    err_t        err;
  } result_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // little-endian byte fill; lane 0 starts a fresh word
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = (pos == 2'd0) ? 32'd0 : w;
    r[pos*8 +: 8] = b;
    return r;
  endfunction

  function automatic result_t make_error(input err_t e, input logic last);
    result_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.err  = e;
    r.last = last;
    return r;
  endfunction

endpackage

/* sv/pcapdf_parser.sv */
// Parser: global header, record header decode, sampling and payload tracking.
module pcapdf_parser import pcapdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  in_byte,
  input  logic        in_eof,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output result_t     res0,
  output result_t     res1,
  output logic [1:0]  res_count
);

  phase_t      phase, phase_next;
  logic [4:0]  cnt, cnt_next;
  logic        reversed, reversed_next;
  logic [15:0] minor, minor_next;
  logic [31:0] magic, magic_next;
  logic [31:0] link_type, link_type_next;
  logic [31:0] rhw [4];
  logic [31:0] rhw_next [4];
  logic [15:0] payload_left, payload_left_next;
  logic        raw_ip, raw_ip_next;
  logic [31:0] lfsr, lfsr_next;
  logic [28:0] prob, prob_next;
  logic [31:0] raw_link, raw_link_next;

  logic [31:0] cur_word, ver_new, lt_new, magic_new;
  logic        magic_ok, rev_new;
  logic [15:0] ver_lo, ver_hi;
  logic [31:0] sec, usec, c_len, l_len, cap, wire_len;
  logic        c_gt_l, l_gt_c, no_swap, bad_rec;
  logic [31:0] lfsr_stepped;
  logic        sampling, keep, raw_new;
  logic [15:0] pl_dec;

  assign cur_word  = put_byte(rhw[cnt[3:2]], cnt[1:0], in_byte);
  assign ver_new   = put_byte(rhw[0], cnt[1:0], in_byte);
  assign lt_new    = put_byte(link_type, cnt[1:0], in_byte);
  assign magic_new = put_byte(magic, cnt[1:0], in_byte);

  assign rev_new  = (magic != PCAP_MAGIC);
  assign magic_ok = (magic == PCAP_MAGIC) || (swap32(magic) == PCAP_MAGIC);
  assign ver_lo   = rev_new ? swap16(rhw[0][15:0]) : rhw[0][15:0];
  assign ver_hi   = rev_new ? swap16(rhw[0][31:16]) : rhw[0][31:16];

  assign sec   = reversed ? swap32(rhw[0]) : rhw[0];
  assign usec  = reversed ? swap32(rhw[1]) : rhw[1];
  assign c_len = reversed ? swap32(rhw[2]) : rhw[2];
  assign l_len = reversed ? swap32(cur_word) : cur_word;

  assign c_gt_l   = c_len > l_len;
  assign l_gt_c   = l_len > c_len;
  assign no_swap  = (minor > 16'd3) || ((minor == 16'd3) && !c_gt_l);
  assign cap      = no_swap ? c_len : l_len;
  assign wire_len = no_swap ? l_len : c_len;
  assign bad_rec  = (no_swap ? c_gt_l : l_gt_c) || (|cap[31:16]);

  assign lfsr_stepped = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
  assign sampling     = prob < FULL_PROB;
  assign keep         = !sampling || ({1'b0, lfsr_stepped[27:0]} < prob);
  assign raw_new      = (link_type == raw_link) && (cap[15:0] >= MIN_IP_LEN);
  assign pl_dec       = payload_left - 16'd1;

  always_comb begin
    phase_next        = phase;
    cnt_next          = cnt;
    reversed_next     = reversed;
    minor_next        = minor;
    magic_next        = magic;
    link_type_next    = link_type;
    rhw_next          = rhw;
    payload_left_next = payload_left;
    raw_ip_next       = raw_ip;
    lfsr_next         = lfsr;
    prob_next         = prob;
    raw_link_next     = raw_link;
    res0              = '0;
    res1              = '0;
    res_count         = 2'd0;

    if (fire) begin
      unique case (phase)
        PH_GLOBAL: begin
          if (cnt < MAGIC_END) begin
            magic_next = magic_new;
          end else if (cnt < VER_END) begin
            rhw_next[0] = ver_new;
          end else if (cnt >= LINK_START) begin
            link_type_next = lt_new;
          end
          cnt_next = cnt + 5'd1;
          if (cnt == GLOBAL_LAST) begin
            cnt_next = '0;
            if (!magic_ok) begin
              res0       = make_error(ERR_BAD_MAGIC, 1'b0);
              res_count  = 2'd1;
              phase_next = PH_STOP;
            end else if (ver_lo != PCAP_MAJOR) begin
              res0       = make_error(ERR_BAD_MAJOR, 1'b0);
              res_count  = 2'd1;
              phase_next = PH_STOP;
            end else begin
              reversed_next  = rev_new;
              minor_next     = ver_hi;
              link_type_next = rev_new ? swap32(lt_new) : lt_new;
              phase_next     = in_eof ? PH_STOP : PH_RECHDR;
            end
          end else if (in_eof) begin
            res0       = make_error(ERR_TOO_SHORT, 1'b0);
            res_count  = 2'd1;
            phase_next = PH_STOP;
          end
        end
        PH_RECHDR: begin
          rhw_next[cnt[3:2]] = cur_word;
          cnt_next           = cnt + 5'd1;
          if (cnt == RECHDR_LAST) begin
            cnt_next = '0;
            if (bad_rec) begin
              res0       = make_error(ERR_BAD_RECORD, 1'b0);
              res_count  = 2'd1;
              phase_next = PH_STOP;
            end else begin
              if (sampling) begin
                lfsr_next = lfsr_stepped;
              end
              payload_left_next = cap[15:0];
              raw_ip_next       = raw_new;
              if (keep) begin
                res0.kind     = KIND_HEADER;
                res0.last     = (cap == 32'd0);
                res0.sec      = sec;
                res0.usec     = usec;
                res0.cap      = cap[15:0];
                res0.wire_len = wire_len;
                res_count     = 2'd1;
              end
              if (cap == 32'd0) begin
                phase_next = PH_RECHDR;
              end else begin
                phase_next = keep ? PH_KEEP : PH_SKIP;
              end
              if (in_eof) begin
                if (keep && (cap != 32'd0)) begin
                  res1      = make_error(ERR_SHORT_PACKET, 1'b1);
                  res_count = 2'd2;
                end
                phase_next = PH_STOP;
              end
            end
          end else if (in_eof) begin
            phase_next = PH_STOP;
          end
        end
        PH_KEEP: begin
          raw_ip_next       = 1'b0;
          payload_left_next = pl_dec;
          res0.kind         = KIND_PAYLOAD;
          res0.payload_byte = in_byte;
          res0.last         = (pl_dec == 16'd0);
          res0.ip           = raw_ip ? {in_byte[3:0], 2'b00} : 6'd0;
          res_count         = 2'd1;
          if (pl_dec == 16'd0) begin
            phase_next = PH_RECHDR;
          end
          if (in_eof) begin
            if (pl_dec != 16'd0) begin
              res1      = make_error(ERR_SHORT_PACKET, 1'b1);
              res_count = 2'd2;
            end
            phase_next = PH_STOP;
          end
        end
        PH_SKIP: begin
          payload_left_next = pl_dec;
          if (pl_dec == 16'd0) begin
            phase_next = PH_RECHDR;
          end
          if (in_eof) begin
            phase_next = PH_STOP;
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_write) begin
      unique case (cfg_index)
        CFG_PROB:     prob_next = cfg_data[28:0];
        CFG_SEED:     lfsr_next = (cfg_data == 32'd0) ? SEED_RESET : cfg_data;
        CFG_RAW_LINK: raw_link_next = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_GLOBAL;
      cnt          <= '0;
      reversed     <= 1'b0;
      minor        <= '0;
      magic        <= '0;
      link_type    <= '0;
      payload_left <= '0;
      raw_ip       <= 1'b0;
      lfsr         <= SEED_RESET;
      prob         <= FULL_PROB;
      raw_link     <= RAW_LINK_RESET;
    end else begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      reversed     <= reversed_next;
      minor        <= minor_next;
      magic        <= magic_next;
      link_type    <= link_type_next;
      payload_left <= payload_left_next;
      raw_ip       <= raw_ip_next;
      lfsr         <= lfsr_next;
      prob         <= prob_next;
      raw_link     <= raw_link_next;
    end
  end

  always_ff @(posedge clk) begin
    rhw <= rhw_next;
  end

endmodule

/* sv/pcapdf_rqueue.sv */
// Result queue: takes up to two results a cycle, hands out one.
module pcapdf_rqueue import pcapdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    res0,
  input  result_t    res1,
  input  logic       pop,
  output result_t    head,
  output logic       not_empty,
  output logic       space
);

  result_t          q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr, rd_ptr;
  logic [RQ_AW:0]   count, count_next;

  assign head       = q[rd_ptr];
  assign not_empty  = (count != '0);
  assign space      = (count <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign count_next = count + (RQ_AW+1)'(push_count) - (RQ_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      q[wr_ptr] <= res0;
    end
    if (push_count == 2'd2) begin
      q[wr_ptr + RQ_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_AW'(push_count);
      rd_ptr <= rd_ptr + RQ_AW'(pop);
      count  <= count_next;
    end
  end

endmodule

/* sv/pcap_record_deframer_unit.sv */
// Top level of the pcap record deframer: input register, parser and result queue.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    file_byte, end_of_file
//   out      source     out_valid / out_stall  kind .. error_code (one result per request)
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// One byte per cycle while in_stall is low: a byte is parsed while it sits in the
// input register and its results enter the queue at the next edge, so each result
// passes through the input register and then the queue before it is on the output.
// A byte may yield two results; the four-entry queue absorbs the extra one.
// in_stall rises only while the queue holds more than two results.
// rst is synchronous; after it the block expects a global header.
module pcap_record_deframer_unit import pcapdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        last_of_packet,
  output logic [31:0] stamp_seconds,
  output logic [31:0] stamp_micros,
  output logic [15:0] captured_length,
  output logic [31:0] wire_length,
  output logic [5:0]  ip_header_bytes,
  output logic [2:0]  error_code,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eof;
  logic       fire, space, accept, pop;
  result_t    res0, res1, head;
  logic [1:0] res_count;

  assign fire     = in_full && space;
  assign in_stall = in_full && !space;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= file_byte;
      in_eof  <= end_of_file;
    end
  end

  pcapdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_byte   (in_byte),
    .in_eof    (in_eof),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  pcapdf_rqueue u_rqueue (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .res0       (res0),
    .res1       (res1),
    .pop        (pop),
    .head       (head),
    .not_empty  (out_valid),
    .space      (space)
  );

  assign kind            = head.kind;
  assign payload_byte    = head.payload_byte;
  assign last_of_packet  = head.last;
  assign stamp_seconds   = head.sec;
  assign stamp_micros    = head.usec;
  assign captured_length = head.cap;
  assign wire_length     = head.wire_len;
  assign ip_header_bytes = head.ip;
  assign error_code      = head.err;

endmodule

/* sv/pcapdf_checker.sv */
// Checker on the deframer's ports, bound to the top level.
module pcapdf_checker import pcapdf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [7:0]  payload_byte,
  input logic        last_of_packet,
  input logic [31:0] stamp_seconds,
  input logic [15:0] captured_length,
  input logic [2:0]  error_code
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_HEADER) |-> (last_of_packet == (captured_length == 16'd0)))
    else $error("header last flag disagrees with captured length");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERROR) |->
      (last_of_packet == (error_code == ERR_SHORT_PACKET)))
    else $error("error request carries wrong last flag");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PAYLOAD) |->
      (stamp_seconds == 32'd0 && captured_length == 16'd0 && error_code == 3'd0))
    else $error("payload request carries header or error fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(payload_byte)))
    else $error("stalled result changed");

endmodule

bind pcap_record_deframer_unit pcapdf_checker u_pcapdf_checker (.*);
